// ===== rtl/rau_pkg.sv =====
`default_nettype none
package rau_pkg;
    localparam int DATA_WIDTH = 32;
    localparam int IO_W       = 32;
    localparam int OP_W       = 3;
    localparam int ST_W       = 2;

    localparam logic [OP_W-1:0] OP_REDUCE = 3'd0;
    localparam logic [OP_W-1:0] OP_NEGATE = 3'd1;
    localparam logic [OP_W-1:0] OP_ADD    = 3'd2;
    localparam logic [OP_W-1:0] OP_MUL    = 3'd3;
    localparam logic [OP_W-1:0] OP_DIV    = 3'd4;

    localparam logic [ST_W-1:0] ST_OK       = 2'd0;
    localparam logic [ST_W-1:0] ST_ZERO_DEN = 2'd1;
    localparam logic [ST_W-1:0] ST_RANGE    = 2'd2;
endpackage
`default_nettype wire

// ===== rtl/rau_div.sv =====
`default_nettype none
module rau_div #(
    parameter int DW = rau_pkg::DATA_WIDTH
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_start,
    input  wire logic signed [DW-1:0] i_dividend,
    input  wire logic signed [DW-1:0] i_divisor,
    output logic                      o_done,
    output logic signed [DW:0]        o_quo,
    output logic signed [DW-1:0]      o_rem
);
    import rau_pkg::*;

    localparam int CW = $clog2(DW + 1);

    logic          r_busy, r_done, r_qneg, r_rneg;
    logic [CW-1:0] r_cnt;
    logic [DW-1:0] r_rem, r_q, r_dvs;
    logic [DW-1:0] rem_sh;
    logic [DW:0]   diff;
    logic [DW-1:0] dvd_mag, dvs_mag;

    // restoring divide on magnitudes, one quotient bit per cycle
    assign dvd_mag = i_dividend[DW-1] ? DW'(-i_dividend) : DW'(i_dividend);
    assign dvs_mag = i_divisor[DW-1]  ? DW'(-i_divisor)  : DW'(i_divisor);
    assign rem_sh  = {r_rem[DW-2:0], r_q[DW-1]};
    assign diff    = {1'b0, rem_sh} - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(DW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q    <= dvd_mag;
            r_dvs  <= dvs_mag;
            r_rem  <= '0;
            r_qneg <= i_dividend[DW-1] ^ i_divisor[DW-1];
            r_rneg <= i_dividend[DW-1];
        end else if (r_busy) begin
            r_rem <= diff[DW] ? rem_sh : diff[DW-1:0];
            r_q   <= {r_q[DW-2:0], ~diff[DW]};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_qneg ? -$signed({1'b0, r_q}) : $signed({1'b0, r_q});
    assign o_rem  = r_rneg ? -$signed(r_rem) : $signed(r_rem);
endmodule
`default_nettype wire

// ===== rtl/rational_arithmetic_unit.sv =====
// Rational arithmetic unit: reduce, negate, add, multiply or divide fractions, each
// operand and the outcome reduced by a truncated-remainder Euclidean GCD. One
// item at a time; the input stalls while an item is worked on, and the next item
// may be taken while a result waits at the output. All division runs on one shared
// restoring divider that yields one bit per cycle. An item runs one to three
// reductions, plus the products between them for add, multiply and divide.
// Status 1 flags a zero denominator, status 2 a value outside DATA_WIDTH signed
// bits; both give 0/0.
`default_nettype none
module rational_arithmetic_unit #(
    parameter int DATA_WIDTH = rau_pkg::DATA_WIDTH
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_in_valid,
    output logic                           o_in_stall,
    input  wire logic [rau_pkg::OP_W-1:0]  i_req_type,
    input  wire logic signed [rau_pkg::IO_W-1:0] i_num_a,
    input  wire logic signed [rau_pkg::IO_W-1:0] i_den_a,
    input  wire logic signed [rau_pkg::IO_W-1:0] i_num_b,
    input  wire logic signed [rau_pkg::IO_W-1:0] i_den_b,
    output logic                           o_out_valid,
    input  wire logic                      i_out_stall,
    output logic signed [rau_pkg::IO_W-1:0] o_res_num,
    output logic signed [rau_pkg::IO_W-1:0] o_res_den,
    output logic [rau_pkg::ST_W-1:0]       o_status
);
    import rau_pkg::*;

    localparam int DW = DATA_WIDTH;

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_RSTART = 9'b000000010,
        S_RMOD   = 9'b000000100,
        S_RDIVP  = 9'b000001000,
        S_RDIVQ  = 9'b000010000,
        S_NEXT   = 9'b000100000,
        S_MUL    = 9'b001000000,
        S_MCHK   = 9'b010000000,
        S_FIN    = 9'b100000000
    } t_state;

    typedef enum logic [1:0] {P_A, P_B, P_C} t_pass;

    t_state r_state, n_state;
    t_pass  r_pass, n_pass;
    logic [OP_W-1:0] r_op, n_op;
    logic [ST_W-1:0] r_st, n_st;
    logic [1:0]      r_slot, n_slot;
    logic signed [DW-1:0] r_bn, n_bn, r_bd, n_bd;
    logic signed [DW-1:0] r_p, n_p, r_q, n_q, r_w, n_w;
    logic signed [DW-1:0] r_rp, n_rp, r_rq, n_rq;
    logic signed [DW-1:0] r_xp, n_xp, r_xq, n_xq, r_yp, n_yp, r_yq, n_yq;
    logic signed [DW-1:0] r_top, n_top, r_bot, n_bot;
    logic signed [DW-1:0] r_rn, n_rn, r_rd, n_rd;
    logic signed [2*DW-1:0] r_prod;
    logic                 r_ov;
    logic [ST_W-1:0]      r_ost;
    logic signed [DW-1:0] r_onum, r_oden;

    logic                 div_start, div_done;
    logic signed [DW-1:0] div_dvd, div_dvs, div_rem;
    logic signed [DW:0]   div_quo;
    logic signed [DW-1:0] mul_a, mul_b;
    logic signed [DW:0]   sum;
    logic                 prod_ovf, quo_ovf, accept, fin_load;

    rau_div #(.DW(DW)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dvd),
        .i_divisor  (div_dvs),
        .o_done     (div_done),
        .o_quo      (div_quo),
        .o_rem      (div_rem)
    );

    assign accept   = i_in_valid && (r_state == S_IDLE);
    assign fin_load = (r_state == S_FIN) && (!r_ov || !i_out_stall);
    assign quo_ovf  = div_quo[DW] != div_quo[DW-1];
    assign prod_ovf = !((&r_prod[2*DW-1:DW-1]) || !(|r_prod[2*DW-1:DW-1]));
    assign sum      = {r_top[DW-1], r_top} + {r_prod[DW-1], r_prod[DW-1:0]};

    always_comb begin
        mul_a = r_xq;
        mul_b = r_yq;
        case (r_slot)
            2'd0: begin
                mul_a = r_xp;
                mul_b = (r_op == OP_MUL) ? r_yp : r_yq;
            end
            2'd1: begin
                mul_a = r_xq;
                mul_b = (r_op == OP_DIV) ? r_yp : r_yq;
            end
            default: begin
                mul_a = r_yp;
                mul_b = r_xq;
            end
        endcase
    end

    always_comb begin
        n_state = r_state; n_pass = r_pass; n_op = r_op; n_st = r_st; n_slot = r_slot;
        n_bn = r_bn; n_bd = r_bd; n_p = r_p; n_q = r_q; n_w = r_w;
        n_rp = r_rp; n_rq = r_rq; n_xp = r_xp; n_xq = r_xq; n_yp = r_yp; n_yq = r_yq;
        n_top = r_top; n_bot = r_bot; n_rn = r_rn; n_rd = r_rd;
        div_start = 1'b0;
        div_dvd   = r_p;
        div_dvs   = r_q;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_op    = i_req_type;
                    n_p     = i_num_a[DW-1:0];
                    n_q     = i_den_a[DW-1:0];
                    n_bn    = i_num_b[DW-1:0];
                    n_bd    = i_den_b[DW-1:0];
                    n_st    = ST_OK;
                    n_pass  = P_A;
                    n_state = S_RSTART;
                end
            end
            S_RSTART: begin
                if (r_q == '0) begin
                    n_st    = ST_ZERO_DEN;
                    n_state = S_FIN;
                end else begin
                    div_start = 1'b1;
                    n_w       = r_q;
                    n_state   = S_RMOD;
                end
            end
            S_RMOD: begin
                if (div_done) begin
                    div_start = 1'b1;
                    if (div_rem == '0) begin
                        div_dvd = r_p;
                        div_dvs = r_w;
                        n_state = S_RDIVP;
                    end else begin
                        div_dvd = r_w;
                        div_dvs = div_rem;
                        n_w     = div_rem;
                    end
                end
            end
            S_RDIVP: begin
                if (div_done) begin
                    if (quo_ovf) begin
                        n_st    = ST_RANGE;
                        n_state = S_FIN;
                    end else begin
                        n_rp      = div_quo[DW-1:0];
                        div_start = 1'b1;
                        div_dvd   = r_q;
                        div_dvs   = r_w;
                        n_state   = S_RDIVQ;
                    end
                end
            end
            S_RDIVQ: begin
                if (div_done) begin
                    if (quo_ovf) begin
                        n_st    = ST_RANGE;
                        n_state = S_FIN;
                    end else begin
                        n_rq    = div_quo[DW-1:0];
                        n_state = S_NEXT;
                    end
                end
            end
            S_NEXT: begin
                n_state = S_FIN;
                case (r_pass)
                    P_A: begin
                        n_xp = r_rp;
                        n_xq = r_rq;
                        n_rn = r_rp;
                        n_rd = r_rq;
                        if (r_op == OP_NEGATE) begin
                            n_rn = -r_rp;
                            if (r_rp == {1'b1, {(DW-1){1'b0}}}) begin
                                n_st = ST_RANGE;
                            end
                        end else if (r_op == OP_ADD || r_op == OP_MUL || r_op == OP_DIV) begin
                            n_p     = r_bn;
                            n_q     = r_bd;
                            n_pass  = P_B;
                            n_state = S_RSTART;
                        end
                    end
                    P_B: begin
                        n_yp    = r_rp;
                        n_yq    = r_rq;
                        n_slot  = 2'd0;
                        n_state = S_MUL;
                    end
                    default: begin
                        n_rn = r_rp;
                        n_rd = r_rq;
                    end
                endcase
            end
            S_MUL: begin
                n_state = S_MCHK;
            end
            S_MCHK: begin
                if (r_slot == 2'd0) begin
                    n_top = r_prod[DW-1:0];
                end else if (r_slot == 2'd1) begin
                    n_bot = r_prod[DW-1:0];
                end
                if (prod_ovf) begin
                    n_st    = ST_RANGE;
                    n_state = S_FIN;
                end else if (r_slot == 2'd0 || (r_slot == 2'd1 && r_op == OP_ADD)) begin
                    n_slot  = r_slot + 2'd1;
                    n_state = S_MUL;
                end else if (r_slot == 2'd1) begin
                    n_p     = r_top;
                    n_q     = r_prod[DW-1:0];
                    n_pass  = P_C;
                    n_state = S_RSTART;
                end else begin
                    // add: numerator sum
                    n_p     = sum[DW-1:0];
                    n_q     = r_bot;
                    n_pass  = P_C;
                    n_state = S_RSTART;
                    if (sum[DW] != sum[DW-1]) begin
                        n_st    = ST_RANGE;
                        n_state = S_FIN;
                    end
                end
            end
            S_FIN: begin
                if (fin_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (fin_load) begin
                r_ov <= 1'b1;
            end else if (!i_out_stall) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pass <= n_pass; r_op <= n_op; r_st <= n_st; r_slot <= n_slot;
        r_bn <= n_bn; r_bd <= n_bd; r_p <= n_p; r_q <= n_q; r_w <= n_w;
        r_rp <= n_rp; r_rq <= n_rq; r_xp <= n_xp; r_xq <= n_xq; r_yp <= n_yp; r_yq <= n_yq;
        r_top <= n_top; r_bot <= n_bot; r_rn <= n_rn; r_rd <= n_rd;
        r_prod <= mul_a * mul_b;
        if (fin_load) begin
            r_ost  <= r_st;
            r_onum <= (r_st == ST_OK) ? r_rn : '0;
            r_oden <= (r_st == ST_OK) ? r_rd : '0;
        end
    end

    assign o_in_stall  = r_state != S_IDLE;
    assign o_out_valid = r_ov;
    assign o_status    = r_ost;
    assign o_res_num   = IO_W'(r_onum);
    assign o_res_den   = IO_W'(r_oden);

    a_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n) $onehot(r_state))
        else $error("state not one-hot");
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status != ST_OK |-> o_res_num == '0 && o_res_den == '0)
        else $error("fault result not 0/0");
    a_ok_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == ST_OK |-> o_res_den != '0)
        else $error("ok result with zero denominator");
    a_idle_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_IDLE || r_state == S_FIN |-> !div_done)
        else $error("divider finished outside a reduction");
endmodule
`default_nettype wire
